// File: src/three_axis_block_averager_assert.svh
// Assertion macros for the three-axis block averager.
// Each macro takes a label, the clock, the active-low reset and the
// property terms; synthesis builds see empty bodies.
`ifndef THREE_AXIS_BLOCK_AVERAGER_ASSERT_SVH
`define THREE_AXIS_BLOCK_AVERAGER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define TAB_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define TAB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define TAB_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define TAB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: src/tab_pkg.sv
package tab_pkg;

	// field widths
	localparam int SAMPLE_W   = 12;
	localparam int SUM_W      = 18;
	localparam int WIN_W      = 7;
	localparam int AXIS_W     = 2;

	// window limits
	localparam int MAX_WINDOW   = 64;
	localparam int RESET_WINDOW = 4;

	// number of axes and the codes that name them
	localparam int NUM_AXES = 3;
	localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
	localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
	localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

	// divider step counter: one quotient bit per step
	localparam int CNT_W = $clog2(SUM_W + 1);

	// divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// limit a register write to 1..MAX_WINDOW
	function automatic logic [WIN_W-1:0] clamp_window(input logic [WIN_W-1:0] w);
		logic [WIN_W-1:0] r;
		r = w;
		if (w > WIN_W'(MAX_WINDOW)) begin
			r = WIN_W'(MAX_WINDOW);
		end
		if (w == '0) begin
			r = WIN_W'(1);
		end
		return r;
	endfunction

endpackage

// File: src/three_axis_block_averager.sv
// Three-axis boxcar averager. Each sample beat adds its reading into the
// running sum of its axis (x, y or z; axis code 3 is dropped). When an
// axis has collected window_size samples (the very first result per axis
// comes after one sample) the sum is divided by window_size, truncated
// toward zero, and sent out as one result beat; the sum then clears and
// the countdown reloads. A sample that completes a window holds off the
// next sample through its accept, 18 steps of the shared bit-serial
// divider, and the hand-off of the quotient to the output register.
// The output register holds a result while the next samples are
// accepted; a second quotient waits in the divider until it frees.
// window_size is clamped to 1..64 on write and must be written only while
// the block is idle; a countdown already running keeps its count.
`include "three_axis_block_averager_assert.svh"

module three_axis_block_averager (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tab_pkg::WIN_W-1:0]           window_size,
	// sample channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [tab_pkg::AXIS_W-1:0]          axis,
	input  logic signed [tab_pkg::SAMPLE_W-1:0] sample,
	// result channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [tab_pkg::AXIS_W-1:0]          axis_out,
	output logic signed [tab_pkg::SUM_W-1:0]    average
);
	import tab_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DIV  = 1'b1;

	logic                    state_q;
	logic [WIN_W-1:0]        window_q;
	logic signed [SUM_W-1:0] sum_q [NUM_AXES];
	logic [WIN_W-1:0]        cnt_q [NUM_AXES];
	logic [AXIS_W-1:0]       axis_pend_q;

	logic                    out_valid_q;
	logic [AXIS_W-1:0]       axis_out_q;
	logic signed [SUM_W-1:0] average_q;

	logic                    in_fire;
	logic                    axis_ok;
	logic                    emit;
	logic signed [SUM_W-1:0] sum_new;
	logic                    div_start;
	logic                    out_load;
	div_stat_t               div_stat;
	logic signed [SUM_W-1:0] div_quo;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid & in_ready;
	assign axis_ok   = (axis == AXIS_X) || (axis == AXIS_Y) || (axis == AXIS_Z);

	// accumulate the beat into its axis sum
	always_comb begin
		sum_new = '0;
		emit    = 1'b0;
		if (axis_ok) begin
			sum_new = sum_q[axis] +
				{{(SUM_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
			emit    = (cnt_q[axis] <= WIN_W'(1));
		end
	end

	assign div_start = in_fire & axis_ok & emit;
	assign out_load  = (state_q == ST_DIV) & div_stat.done & (~out_valid_q | out_ready);

	// shared divider
	tab_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_new),
		.divisor  (window_q),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	// window register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= clamp_window(WIN_W'(RESET_WINDOW));
		end else if (cfg_valid & cfg_ready) begin
			window_q <= clamp_window(window_size);
		end
	end

	// per-axis sums and countdowns
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				sum_q[i] <= '0;
				cnt_q[i] <= WIN_W'(1);
			end
		end else if (in_fire & axis_ok) begin
			if (emit) begin
				sum_q[axis] <= '0;
				cnt_q[axis] <= window_q;
			end else begin
				sum_q[axis] <= sum_new;
				cnt_q[axis] <= cnt_q[axis] - WIN_W'(1);
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (div_start) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			axis_pend_q <= axis;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			axis_out_q <= axis_pend_q;
			average_q  <= div_quo;
		end
	end

	assign out_valid = out_valid_q;
	assign axis_out  = axis_out_q;
	assign average   = average_q;

	// checks
	`TAB_ASSERT_NEXT(a_div_starts, clk, arst_n, div_start, div_stat.busy && (state_q == ST_DIV))
	`TAB_ASSERT_IMPLIES(a_result_from_div, clk, arst_n, $rose(out_valid_q), $past(div_stat.done))
	`TAB_ASSERT_IMPLIES(a_cnt_nonzero, clk, arst_n, 1'b1, (cnt_q[0] != '0) && (cnt_q[1] != '0) && (cnt_q[2] != '0))
	`TAB_ASSERT_IMPLIES(a_window_range, clk, arst_n, 1'b1, (window_q != '0) && (window_q <= WIN_W'(MAX_WINDOW)))

endmodule

// File: src/tab_div.sv
// Bit-serial signed divider: signed sum by unsigned window, truncated
// toward zero. One restoring step per cycle, SUM_W steps per division.
module tab_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [tab_pkg::SUM_W-1:0] dividend,
	input  logic [tab_pkg::WIN_W-1:0]     divisor,
	output tab_pkg::div_stat_t            stat,
	output logic signed [tab_pkg::SUM_W-1:0] quotient
);
	import tab_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WIN_W-1:0] rem_q;
	logic [SUM_W-1:0] mag_q;
	logic [WIN_W-1:0] div_q;
	logic             neg_q;

	logic [WIN_W:0]   shifted;
	logic [WIN_W+1:0] diff;
	logic             q_bit;
	logic [WIN_W-1:0] rem_nxt;
	logic [SUM_W-1:0] dividend_neg;

	// one restoring step: shift in next dividend bit, try subtract
	always_comb begin
		shifted      = {rem_q, mag_q[SUM_W-1]};
		diff         = {1'b0, shifted} - {2'b00, div_q};
		q_bit        = ~diff[WIN_W+1];
		rem_nxt      = q_bit ? diff[WIN_W-1:0] : shifted[WIN_W-1:0];
		dividend_neg = -dividend;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(SUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			mag_q <= dividend[SUM_W-1] ? dividend_neg : dividend;
			neg_q <= dividend[SUM_W-1];
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			mag_q <= {mag_q[SUM_W-2:0], q_bit};
		end
	end

	// restore the sign; magnitude 2^17 negates to the most negative value
	assign quotient  = neg_q ? -mag_q : mag_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// File: dv/three_axis_block_averager_checker.sv
// Watches the sample, window and result channels of the averager, keeps its own
// per-axis sums and countdowns, and checks every result beat against the
// oldest average still due.
module three_axis_block_averager_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [tab_pkg::WIN_W-1:0]           window_size,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic [tab_pkg::AXIS_W-1:0]          axis,
	input  logic signed [tab_pkg::SAMPLE_W-1:0] sample,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic [tab_pkg::AXIS_W-1:0]          axis_out,
	input  logic signed [tab_pkg::SUM_W-1:0]    average,
	output int                                  mismatches,
	output int                                  results_due
);
	import tab_pkg::*;

	typedef struct packed {
		logic [AXIS_W-1:0]       ax;
		logic signed [SUM_W-1:0] avg;
	} axis_avg_t;

	axis_avg_t               avg_due_q [$];
	logic signed [SUM_W-1:0] run_sum [NUM_AXES];
	logic [WIN_W-1:0]        run_left [NUM_AXES];
	logic [WIN_W-1:0]        win_now;

	initial mismatches = 0;

	// writes land in 1..MAX_WINDOW
	function automatic logic [WIN_W-1:0] limit_window(input logic [WIN_W-1:0] w);
		if (w > WIN_W'(MAX_WINDOW)) begin
			return WIN_W'(MAX_WINDOW);
		end
		if (w == '0) begin
			return WIN_W'(1);
		end
		return w;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] averager check: %s", $time, msg);
		mismatches++;
	endtask

	// add one sample into its axis; a finished window queues its average
	task automatic fold_sample(input logic [AXIS_W-1:0] a,
			input logic signed [SAMPLE_W-1:0] s);
		int k;
		int quo;
		axis_avg_t due;
		k = int'(a);
		// sum wraps at SUM_W bits
		run_sum[k] = run_sum[k] + {{(SUM_W-SAMPLE_W){s[SAMPLE_W-1]}}, s};
		if (run_left[k] > WIN_W'(1)) begin
			run_left[k] = run_left[k] - 1'b1;
		end else begin
			// int division truncates toward zero; window taken as of now
			quo = int'(run_sum[k]) / int'(win_now);
			due.ax = a;
			due.avg = SUM_W'(quo);
			avg_due_q.push_back(due);
			run_left[k] = win_now;
			run_sum[k] = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		axis_avg_t oldest;
		if (!arst_n) begin
			avg_due_q.delete();
			for (int i = 0; i < NUM_AXES; i++) begin
				run_sum[i] = '0;
				run_left[i] = WIN_W'(1);
			end
			win_now = limit_window(WIN_W'(RESET_WINDOW));
			results_due <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				win_now = limit_window(window_size);
			end
			// result beat: pop before this edge's sample can queue anything
			if (out_valid && out_ready) begin
				if (avg_due_q.size() == 0) begin
					report_mismatch($sformatf("result with nothing due: axis %0d average %0d",
						axis_out, average));
				end else begin
					oldest = avg_due_q.pop_front();
					if (axis_out !== oldest.ax) begin
						report_mismatch($sformatf("axis_out %0d, want %0d",
							axis_out, oldest.ax));
					end
					if (average !== oldest.avg) begin
						report_mismatch($sformatf("average %0d on axis %0d, want %0d",
							average, oldest.ax, oldest.avg));
					end
				end
			end
			// unused axis code is dropped
			if (in_valid && in_ready && axis <= AXIS_Z) begin
				fold_sample(axis, sample);
			end
			results_due <= avg_due_q.size();
		end
	end

endmodule

// File: dv/three_axis_block_averager_tb.sv
module three_axis_block_averager_tb;
	import tab_pkg::*;

	localparam logic [AXIS_W-1:0]          AXIS_UNUSED = 2'd3;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 12'sh800;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 12'sh7FF;
	localparam int DIRECTED      = 19;
	localparam int PHASES        = 12;
	localparam int SETTLE_CYCLES = 25;
	localparam int CYCLE_LIMIT   = 400000;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [WIN_W-1:0]           window_size;
	logic                       in_valid;
	logic                       in_ready;
	logic [AXIS_W-1:0]          axis;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       out_valid;
	logic                       out_ready;
	logic [AXIS_W-1:0]          axis_out;
	logic signed [SUM_W-1:0]    average;
	int                         mismatches;
	int                         results_due;
	int                         cycle_count = 0;
	bit                         tx_steady = 1'b0;

	always #5 clk = ~clk;

	three_axis_block_averager u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .window_size(window_size),
		.in_valid(in_valid), .in_ready(in_ready), .axis(axis), .sample(sample),
		.out_valid(out_valid), .out_ready(out_ready), .axis_out(axis_out),
		.average(average)
	);

	three_axis_block_averager_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .window_size(window_size),
		.in_valid(in_valid), .in_ready(in_ready), .axis(axis), .sample(sample),
		.out_valid(out_valid), .out_ready(out_ready), .axis_out(axis_out),
		.average(average), .mismatches(mismatches), .results_due(results_due)
	);

	// one sample beat; called and returns on a rising edge
	task automatic send_sample(input logic [AXIS_W-1:0] a, input logic signed [SAMPLE_W-1:0] s);
		int gap;
		if ($urandom_range(0, 39) == 0) begin
			tx_steady = !tx_steady;
		end
		gap = tx_steady ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		axis <= a;
		sample <= s;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic write_window(input logic [WIN_W-1:0] w);
		cfg_valid <= 1'b1;
		window_size <= w;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// stop sending, let every due average come out, then let the divider settle
	task automatic wait_for_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (results_due != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// run guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// result side: random stall per beat, with stretches of none
	initial begin : result_sink
		int stall;
		bit rx_steady;
		rx_steady = 1'b0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0) begin
				rx_steady = !rx_steady;
			end
			stall = rx_steady ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				out_ready <= 1'b0;
				do @(posedge clk); while (!out_valid);
				repeat (stall - 1) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	initial begin : stimulus
		int r;
		int n_items;
		logic [AXIS_W-1:0] a;
		logic signed [SAMPLE_W-1:0] s;
		logic [WIN_W-1:0] w;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		window_size = '0;
		in_valid = 1'b0;
		axis = AXIS_X;
		sample = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset window of 4: first sample per axis finishes at once,
		// negative sums truncate toward zero, unused axis is dropped, and X is
		// left two samples short so the next window write lands mid-count
		for (int i = 0; i < DIRECTED; i++) begin
			case (i)
				0:  begin a = AXIS_X;      s = -12'sd2047; end
				1:  begin a = AXIS_Y;      s = SAMPLE_MAX; end
				2:  begin a = AXIS_Z;      s = SAMPLE_MIN; end
				3:  begin a = AXIS_UNUSED; s = SAMPLE_MAX; end
				4:  begin a = AXIS_X;      s = -12'sd1;    end
				5:  begin a = AXIS_Y;      s = SAMPLE_MIN; end
				6:  begin a = AXIS_X;      s = -12'sd1;    end
				7:  begin a = AXIS_Z;      s = SAMPLE_MAX; end
				8:  begin a = AXIS_Y;      s = SAMPLE_MIN; end
				9:  begin a = AXIS_X;      s = -12'sd1;    end
				10: begin a = AXIS_Z;      s = SAMPLE_MAX; end
				11: begin a = AXIS_Y;      s = SAMPLE_MIN; end
				12: begin a = AXIS_UNUSED; s = SAMPLE_MIN; end
				13: begin a = AXIS_Z;      s = SAMPLE_MAX; end
				14: begin a = AXIS_X;      s = 12'sd0;     end
				15: begin a = AXIS_Y;      s = SAMPLE_MIN; end
				16: begin a = AXIS_Z;      s = 12'sd1;     end
				17: begin a = AXIS_X;      s = 12'sd5;     end
				default: begin a = AXIS_X; s = 12'sd7;     end
			endcase
			send_sample(a, s);
		end

		// random phases, each under its own window setting
		for (int p = 0; p < PHASES; p++) begin
			wait_for_results();
			case (p)
				0: w = WIN_W'(1);
				1: w = WIN_W'(MAX_WINDOW);
				2: w = '0;
				3: w = '1;
				4: w = WIN_W'(MAX_WINDOW + 1);
				5: w = WIN_W'(2);
				6: w = WIN_W'(3);
				7, 8: w = WIN_W'($urandom_range(0, 127));
				default: w = WIN_W'($urandom_range(1, 8));
			endcase
			write_window(w);
			n_items = (p == 1 || p == 3) ? 200 : 75;
			for (int i = 0; i < n_items; i++) begin
				r = $urandom_range(0, 15);
				// in the full-window phase X gets extra weight to fill a window
				if (r == 0) begin
					a = AXIS_UNUSED;
				end else if (r < 6 || (p == 1 && r < 9)) begin
					a = AXIS_X;
				end else if (r < 11) begin
					a = AXIS_Y;
				end else begin
					a = AXIS_Z;
				end
				// full-window phase drives X and Y to the sum limits
				if (p == 1 && a == AXIS_X) begin
					s = SAMPLE_MIN;
				end else if (p == 1 && a == AXIS_Y) begin
					s = SAMPLE_MAX;
				end else begin
					case ($urandom_range(0, 7))
						0: s = SAMPLE_MIN;
						1: s = SAMPLE_MAX;
						2: s = SAMPLE_W'(int'($urandom_range(0, 8)) - 4);
						default: s = SAMPLE_W'($urandom);
					endcase
				end
				send_sample(a, s);
			end
		end

		wait_for_results();
		if (mismatches == 0 && results_due == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+src
src/tab_pkg.sv
src/tab_div.sv
src/three_axis_block_averager.sv
dv/three_axis_block_averager_checker.sv
dv/three_axis_block_averager_tb.sv
